// File: sv/pwcf_pkg.sv
// Shared types and constants of the probe window composition filter.
// Holds the register map, the configuration bundle and the queued window record.
// No dependencies; every other file of the block uses it.
package pwcf_pkg;

	localparam int MAX_PROBE_LEN  = 32;
	localparam int MAX_PREFIX_LEN = 8;
	localparam int POSITION_BITS  = 24;

	// Bases held by the prefix register (16 bits, two per base).
	localparam int CODE_BASES = 8;
	// Prefix positions that can ever be checked.
	localparam int PFX_CHECK  = (MAX_PREFIX_LEN < MAX_PROBE_LEN) ? MAX_PREFIX_LEN : MAX_PROBE_LEN;

	localparam int LEN_W   = $clog2(MAX_PROBE_LEN + 1);
	localparam int KEY_W   = 2 * MAX_PROBE_LEN;
	localparam int GC_W    = 6;
	localparam int TEMP_W  = 8;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;
	localparam int IN_W    = 8;
	localparam int OUT_RAW = POSITION_BITS + KEY_W + GC_W + TEMP_W;
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_PROBE_LEN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_MIN_GC      = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_GC      = 3'd2;
	localparam logic [IDX_W-1:0] REG_MIN_TEMP    = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_TEMP    = 3'd4;
	localparam logic [IDX_W-1:0] REG_PREFIX_LEN  = 3'd5;
	localparam logic [IDX_W-1:0] REG_PREFIX_CODE = 3'd6;

	typedef struct packed {
		logic [5:0]  win_len;
		logic [5:0]  min_gc_count;
		logic [5:0]  max_gc_count;
		logic [7:0]  min_temp;
		logic [7:0]  max_temp;
		logic [3:0]  pfx_len;
		logic [15:0] prefix_code;
	} cfg_t;

	// One window that passed the run-length check, waiting for evaluation.
	typedef struct packed {
		logic [KEY_W-1:0]         key;
		logic [POSITION_BITS-1:0] start;
		logic [LEN_W-1:0]         len;
	} win_item_t;

endpackage

// File: sv/probe_window_composition_filter_unit.sv
// Top level of the probe window composition filter: configuration registers,
// front end, window queue and back end. Depends on pwcf_pkg, pwcf_front,
// pwcf_queue and pwcf_back.
//
//   channel   direction  beat contents (lowest bits first)
//   s_axis    in         tdata: base_code[2:0], zero fill; tlast: last_base
//   m_axis    out        tdata: window_start[23:0], window_key[63:0],
//                               gc_total[5:0], melt_temp[7:0], zero fill
//   cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// One base beat is taken every cycle while the window queue has room; a qualifying
// result goes through the queue, stage 1 and the output register, each registered.
// Under an output stall the output register, stage 1 and the four-entry queue hold
// six windows before tready drops; windows that go on to fail a check take queue
// entries on their way through as well, but produce no beat.
// Reset restores the register defaults and clears the window, run and position.
module probe_window_composition_filter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pwcf_pkg::IDX_W-1:0]          cfg_index,
	input  logic [pwcf_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [pwcf_pkg::IN_W-1:0]           s_axis_tdata,  // base_code
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// window_start, window_key, gc_total, melt_temp
	output logic [pwcf_pkg::OUT_W-1:0]          m_axis_tdata
);

	pwcf_pkg::cfg_t      cfg_q;
	logic                push;
	pwcf_pkg::win_item_t push_item;
	logic                q_full;
	logic                q_empty;
	logic                q_pop;
	pwcf_pkg::win_item_t q_head;

	// Register file; writes to unused indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_len      <= 6'd18;
			cfg_q.min_gc_count <= 6'd0;
			cfg_q.max_gc_count <= 6'd32;
			cfg_q.min_temp     <= 8'd0;
			cfg_q.max_temp     <= 8'd128;
			cfg_q.pfx_len      <= 4'd0;
			cfg_q.prefix_code  <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pwcf_pkg::REG_PROBE_LEN:   cfg_q.win_len      <= cfg_data[5:0];
				pwcf_pkg::REG_MIN_GC:      cfg_q.min_gc_count <= cfg_data[5:0];
				pwcf_pkg::REG_MAX_GC:      cfg_q.max_gc_count <= cfg_data[5:0];
				pwcf_pkg::REG_MIN_TEMP:    cfg_q.min_temp     <= cfg_data[7:0];
				pwcf_pkg::REG_MAX_TEMP:    cfg_q.max_temp     <= cfg_data[7:0];
				pwcf_pkg::REG_PREFIX_LEN:  cfg_q.pfx_len      <= cfg_data[3:0];
				pwcf_pkg::REG_PREFIX_CODE: cfg_q.prefix_code  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Front end: window shift register, valid run and position counter.
	pwcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.base_code (s_axis_tdata[2:0]),
		.last_base (s_axis_tlast),
		.q_full    (q_full),
		.push      (push),
		.item      (push_item)
	);

	// Decouples base intake from result delivery.
	pwcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// Back end: composition, prefix and temperature checks plus output register.
	pwcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// File: sv/pwcf_front.sv
// Front end of the probe window composition filter: takes bases, keeps the window.
// Produces one masked window record per base whose valid run covers the window.
// Depends on pwcf_pkg.
module pwcf_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pwcf_pkg::cfg_t         cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2:0]             base_code,
	input  logic                   last_base,
	input  logic                   q_full,
	output logic                   push,
	output pwcf_pkg::win_item_t    item
);

	logic [pwcf_pkg::KEY_W-1:0]         window_q;
	logic [pwcf_pkg::LEN_W-1:0]         run_q;
	logic [pwcf_pkg::POSITION_BITS-1:0] pos_q;

	logic                               accept;
	logic [pwcf_pkg::LEN_W-1:0]         n;
	logic [pwcf_pkg::KEY_W-1:0]         win_next;
	logic [pwcf_pkg::KEY_W-1:0]         mask;
	logic [pwcf_pkg::LEN_W-1:0]         run_next;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		// Window length clamped to 1..MAX_PROBE_LEN.
		if (cfg.win_len == '0) begin
			n = pwcf_pkg::LEN_W'(1);
		end else if (cfg.win_len > 6'(pwcf_pkg::MAX_PROBE_LEN)) begin
			n = pwcf_pkg::LEN_W'(pwcf_pkg::MAX_PROBE_LEN);
		end else begin
			n = pwcf_pkg::LEN_W'(cfg.win_len);
		end

		win_next = {window_q[pwcf_pkg::KEY_W-3:0], base_code[1:0]};

		if (base_code[2]) begin
			run_next = '0;
		end else if (run_q < pwcf_pkg::LEN_W'(pwcf_pkg::MAX_PROBE_LEN)) begin
			run_next = run_q + pwcf_pkg::LEN_W'(1);
		end else begin
			run_next = run_q;
		end

		for (int i = 0; i < pwcf_pkg::MAX_PROBE_LEN; i++) begin
			mask[2*i +: 2] = (pwcf_pkg::LEN_W'(i) < n) ? 2'b11 : 2'b00;
		end

		item.key   = win_next & mask;
		item.len   = n;
		item.start = pos_q - {{(pwcf_pkg::POSITION_BITS-pwcf_pkg::LEN_W){1'b0}},
			n - pwcf_pkg::LEN_W'(1)};
		push       = accept && (run_next >= n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			run_q    <= '0;
			pos_q    <= '0;
		end else if (accept) begin
			if (last_base) begin
				window_q <= '0;
				run_q    <= '0;
				pos_q    <= '0;
			end else begin
				window_q <= win_next;
				run_q    <= run_next;
				if (pos_q != '1) begin
					pos_q <= pos_q + pwcf_pkg::POSITION_BITS'(1);
				end
			end
		end
	end

endmodule

// File: sv/pwcf_queue.sv
// Short register queue between the front end and the evaluation back end.
// Holds window records so that either side can stall on its own.
// Depends on pwcf_pkg.
module pwcf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pwcf_pkg::win_item_t push_item,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output pwcf_pkg::win_item_t head
);

	pwcf_pkg::win_item_t               mem_q [pwcf_pkg::QUEUE_DEPTH];
	logic [pwcf_pkg::QPTR_W-1:0]       wr_q;
	logic [pwcf_pkg::QPTR_W-1:0]       rd_q;
	logic [pwcf_pkg::QCNT_W-1:0]       cnt_q;

	assign full  = (cnt_q == pwcf_pkg::QCNT_W'(pwcf_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + pwcf_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + pwcf_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + pwcf_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - pwcf_pkg::QCNT_W'(1);
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !(push && !pop))
		else $error("queue written while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pwcf_pkg::QCNT_W'(pwcf_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// File: sv/pwcf_back.sv
// Back end of the probe window composition filter: evaluates queued windows.
// Stage 1 counts G+C and checks the prefix; the output register keeps passing windows.
// Depends on pwcf_pkg.
module pwcf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pwcf_pkg::cfg_t                cfg,
	input  logic                          q_empty,
	input  pwcf_pkg::win_item_t           q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pwcf_pkg::OUT_W-1:0]    out_data
);

	// Stage 1 registers.
	logic                               valid_s1;
	logic [pwcf_pkg::KEY_W-1:0]         key_s1;
	logic [pwcf_pkg::POSITION_BITS-1:0] start_s1;
	logic [pwcf_pkg::LEN_W-1:0]         len_s1;
	logic [pwcf_pkg::GC_W-1:0]          gc_s1;
	logic                               pfx_ok_s1;

	// Output register.
	logic                               out_valid_q;
	logic [pwcf_pkg::POSITION_BITS-1:0] start_q;
	logic [pwcf_pkg::KEY_W-1:0]         key_q;
	logic [pwcf_pkg::GC_W-1:0]          gc_q;
	logic [pwcf_pkg::TEMP_W-1:0]        temp_q;

	logic [pwcf_pkg::MAX_PROBE_LEN-1:0] gc_flags;
	logic [pwcf_pkg::GC_W-1:0]          gc_c;
	logic [pwcf_pkg::LEN_W:0]           shamt;
	logic [pwcf_pkg::KEY_W-1:0]         aligned;
	logic [pwcf_pkg::LEN_W:0]           plen;
	logic                               pfx_ok_c;
	logic [1:0]                         want;
	logic [pwcf_pkg::TEMP_W-1:0]        temp_c;
	logic                               pass_c;
	logic                               out_free;
	logic                               s1_go;
	logic                               s1_free;

	always_comb begin
		for (int i = 0; i < pwcf_pkg::MAX_PROBE_LEN; i++) begin
			gc_flags[i] = q_head.key[2*i] ^ q_head.key[2*i+1];
		end
		gc_c = pwcf_pkg::GC_W'($countones(gc_flags));

		// Move the earliest base of the window to the top of the word.
		shamt   = {pwcf_pkg::LEN_W'(pwcf_pkg::MAX_PROBE_LEN) - q_head.len, 1'b0};
		aligned = q_head.key << shamt;

		plen = (pwcf_pkg::LEN_W+1)'(cfg.pfx_len);
		if (plen > (pwcf_pkg::LEN_W+1)'(pwcf_pkg::MAX_PREFIX_LEN)) begin
			plen = (pwcf_pkg::LEN_W+1)'(pwcf_pkg::MAX_PREFIX_LEN);
		end
		if (plen > {1'b0, q_head.len}) begin
			plen = {1'b0, q_head.len};
		end

		pfx_ok_c = 1'b1;
		for (int i = 0; i < pwcf_pkg::PFX_CHECK; i++) begin
			want = (i < pwcf_pkg::CODE_BASES) ? cfg.prefix_code[2*i +: 2] : 2'b00;
			if ((pwcf_pkg::LEN_W+1)'(i) < plen &&
				want != aligned[pwcf_pkg::KEY_W-1-2*i -: 2]) begin
				pfx_ok_c = 1'b0;
			end
		end
	end

	// 2*AT + 4*GC with AT = len - GC.
	assign temp_c = pwcf_pkg::TEMP_W'({len_s1, 1'b0}) + pwcf_pkg::TEMP_W'({gc_s1, 1'b0});
	assign pass_c = pfx_ok_s1 &&
		gc_s1 >= cfg.min_gc_count && gc_s1 <= cfg.max_gc_count &&
		temp_c >= cfg.min_temp && temp_c <= cfg.max_temp;

	assign out_free = !out_valid_q || out_ready;
	assign s1_go    = valid_s1 && (!pass_c || out_free);
	assign s1_free  = !valid_s1 || s1_go;
	assign q_pop    = !q_empty && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= q_pop;
			end
			if (out_free) begin
				out_valid_q <= s1_go && pass_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			key_s1    <= q_head.key;
			start_s1  <= q_head.start;
			len_s1    <= q_head.len;
			gc_s1     <= gc_c;
			pfx_ok_s1 <= pfx_ok_c;
		end
		if (out_free && s1_go && pass_c) begin
			start_q <= start_s1;
			key_q   <= key_s1;
			gc_q    <= gc_s1;
			temp_q  <= temp_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = pwcf_pkg::OUT_W'({temp_q, gc_q, key_q, start_q});

`ifndef SYNTH
	a_gc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (gc_q >= cfg.min_gc_count && gc_q <= cfg.max_gc_count))
		else $error("emitted window outside G+C bounds");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for probe_window_composition_filter_unit: drives base beats and register
// writes, predicts every qualifying window and checks each output beat field by field.
// Depends on pwcf_pkg and the filter RTL only.
module tb_top;

	localparam int WATCHDOG_LIMIT = 1000;
	// Extra wait for windows still in the queue, stage 1 or the output register.
	localparam int DRAIN_CYCLES   = 8;
	// Field offsets inside m_axis_tdata.
	localparam int KEY_LSB  = pwcf_pkg::POSITION_BITS;
	localparam int GC_LSB   = KEY_LSB + pwcf_pkg::KEY_W;
	localparam int TEMP_LSB = GC_LSB + pwcf_pkg::GC_W;

	typedef struct packed {
		logic [pwcf_pkg::POSITION_BITS-1:0] start;
		logic [pwcf_pkg::KEY_W-1:0]         key;
		logic [pwcf_pkg::GC_W-1:0]          gc;
		logic [pwcf_pkg::TEMP_W-1:0]        temp;
	} window_hit_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [pwcf_pkg::IDX_W-1:0] cfg_index;
	logic [pwcf_pkg::CFG_W-1:0] cfg_data;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [pwcf_pkg::IN_W-1:0]  s_axis_tdata;
	logic                       s_axis_tlast;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [pwcf_pkg::OUT_W-1:0] m_axis_tdata;

	probe_window_composition_filter_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Model state: a copy of the registers and of the window, run and position.
	pwcf_pkg::cfg_t                     cfg_q = '{win_len: 6'd18, min_gc_count: 6'd0,
		max_gc_count: 6'd32, min_temp: 8'd0, max_temp: 8'd128, pfx_len: 4'd0,
		prefix_code: 16'd0};
	logic [pwcf_pkg::KEY_W-1:0]         window_q = '0;
	int                                 run_q    = 0;
	logic [pwcf_pkg::POSITION_BITS-1:0] pos_q    = '0;

	window_hit_t pending_windows[$];
	int          mismatch_count = 0;
	int          idle_cycles    = 0;
	bit          tx_idle_on     = 1'b1;
	bit          rx_idle_on     = 1'b1;
	int          rx_stall_left  = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Window length as the block uses it: 0 acts as 1, anything above the maximum as
	// the maximum.
	function automatic int window_len();
		int n;
		n = cfg_q.win_len;
		if (n < 1)
			n = 1;
		if (n > pwcf_pkg::MAX_PROBE_LEN)
			n = pwcf_pkg::MAX_PROBE_LEN;
		return n;
	endfunction

	function automatic void apply_reg(input logic [pwcf_pkg::IDX_W-1:0] idx,
		input logic [pwcf_pkg::CFG_W-1:0] data);
		case (idx)
			pwcf_pkg::REG_PROBE_LEN:   cfg_q.win_len      = data[5:0];
			pwcf_pkg::REG_MIN_GC:      cfg_q.min_gc_count = data[5:0];
			pwcf_pkg::REG_MAX_GC:      cfg_q.max_gc_count = data[5:0];
			pwcf_pkg::REG_MIN_TEMP:    cfg_q.min_temp     = data[7:0];
			pwcf_pkg::REG_MAX_TEMP:    cfg_q.max_temp     = data[7:0];
			pwcf_pkg::REG_PREFIX_LEN:  cfg_q.pfx_len      = data[3:0];
			pwcf_pkg::REG_PREFIX_CODE: cfg_q.prefix_code  = data[15:0];
			default: ;
		endcase
	endfunction

	// Shifts one base into the window and decides whether the window that ends on it
	// qualifies. Returns 1 with the expected beat in hit when it does.
	function automatic bit advance_window(input logic [2:0] code, input bit last,
		output window_hit_t hit);
		int                                 n;
		int                                 gc;
		int                                 temp;
		int                                 plen;
		logic [pwcf_pkg::KEY_W-1:0]         key;
		logic [pwcf_pkg::POSITION_BITS-1:0] cur;
		bit                                 ok;

		cur = pos_q;
		n = window_len();
		ok = 1'b0;
		hit = '0;
		window_q = {window_q[pwcf_pkg::KEY_W-3:0], code[1:0]};
		// An invalid symbol breaks the run, so no window holding it can qualify.
		if (code <= 3'd3) begin
			if (run_q < pwcf_pkg::MAX_PROBE_LEN)
				run_q++;
		end else begin
			run_q = 0;
		end
		if (pos_q != '1)
			pos_q++;

		if (run_q >= n) begin
			key = (n >= 32) ? window_q : (window_q & ((64'd1 << (2 * n)) - 64'd1));
			gc = 0;
			for (int i = 0; i < n; i++)
				if (key[2*i +: 2] == 2'd1 || key[2*i +: 2] == 2'd2)
					gc++;
			temp = 2 * (n - gc) + 4 * gc;
			plen = cfg_q.pfx_len;
			if (plen > pwcf_pkg::MAX_PREFIX_LEN)
				plen = pwcf_pkg::MAX_PREFIX_LEN;
			if (plen > n)
				plen = n;
			ok = 1'b1;
			// The earliest base of the window sits at the top of the key.
			for (int i = 0; i < plen; i++)
				if (cfg_q.prefix_code[2*i +: 2] != key[2*(n-1-i) +: 2])
					ok = 1'b0;
			if (gc < cfg_q.min_gc_count || gc > cfg_q.max_gc_count)
				ok = 1'b0;
			if (temp < cfg_q.min_temp || temp > cfg_q.max_temp)
				ok = 1'b0;
			if (ok) begin
				hit.start = cur - pwcf_pkg::POSITION_BITS'(n - 1);
				hit.key   = key;
				hit.gc    = pwcf_pkg::GC_W'(gc);
				hit.temp  = pwcf_pkg::TEMP_W'(temp);
			end
		end

		// The end of a sequence clears the window, the run and the position.
		if (last) begin
			window_q = '0;
			run_q = 0;
			pos_q = '0;
		end
		return ok;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Register writes and accepted bases feed the model; every output beat is compared
	// with the oldest pending window.
	always @(posedge clk) begin : scoreboard
		window_hit_t fresh;
		window_hit_t got;
		window_hit_t want;
		if (arst_n) begin
			if (cfg_we)
				apply_reg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				if (advance_window(s_axis_tdata[2:0], s_axis_tlast, fresh))
					pending_windows.push_back(fresh);
			if (m_axis_tvalid && m_axis_tready) begin
				got.start = m_axis_tdata[pwcf_pkg::POSITION_BITS-1:0];
				got.key   = m_axis_tdata[KEY_LSB +: pwcf_pkg::KEY_W];
				got.gc    = m_axis_tdata[GC_LSB +: pwcf_pkg::GC_W];
				got.temp  = m_axis_tdata[TEMP_LSB +: pwcf_pkg::TEMP_W];
				if (pending_windows.size() == 0) begin
					flag_mismatch("unexpected window beat, start", got.start, '0);
				end else begin
					want = pending_windows.pop_front();
					if (got.start !== want.start)
						flag_mismatch("window_start", got.start, want.start);
					if (got.key !== want.key)
						flag_mismatch("window_key", got.key, want.key);
					if (got.gc !== want.gc)
						flag_mismatch("gc_total", got.gc, want.gc);
					if (got.temp !== want.temp)
						flag_mismatch("melt_temp", got.temp, want.temp);
				end
			end
		end
	end

	// Output back-pressure: mostly ready, with short and occasional long stalls.
	always @(posedge clk) begin
		if (rx_stall_left > 0) begin
			rx_stall_left <= rx_stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 9) < 3) begin
			rx_stall_left <= pick_gap() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Any accepted beat or register write counts as progress.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no progress for %0d cycles", $realtime, idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Sends one base beat, with an optional gap first, and returns once it is taken.
	task automatic send_base(input logic [2:0] code, input bit last);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(pwcf_pkg::IN_W-3){1'b0}}, code};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Stops the input and waits until every predicted window is out and the pipeline
	// has had time to finish bases that produce nothing.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_windows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [pwcf_pkg::IDX_W-1:0] idx,
		input logic [pwcf_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Writes all seven registers. Bits above each register's width carry noise that
	// the block must drop.
	task automatic program_filter(input int len_v, input int min_gc, input int max_gc,
		input int min_t, input int max_t, input int plen, input logic [15:0] pcode);
		logic [pwcf_pkg::CFG_W-1:0] noise;
		noise = pwcf_pkg::CFG_W'($urandom);
		put_reg(pwcf_pkg::REG_PROBE_LEN,   {noise[15:6], 6'(len_v)});
		put_reg(pwcf_pkg::REG_MIN_GC,      {noise[15:6], 6'(min_gc)});
		put_reg(pwcf_pkg::REG_MAX_GC,      {noise[15:6], 6'(max_gc)});
		put_reg(pwcf_pkg::REG_MIN_TEMP,    {noise[15:8], 8'(min_t)});
		put_reg(pwcf_pkg::REG_MAX_TEMP,    {noise[15:8], 8'(max_t)});
		put_reg(pwcf_pkg::REG_PREFIX_LEN,  {noise[15:4], 4'(plen)});
		put_reg(pwcf_pkg::REG_PREFIX_CODE, pcode);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [2:0] rand_base();
		if ($urandom_range(0, 24) == 0)
			return 3'($urandom_range(4, 7));
		return 3'($urandom_range(0, 3));
	endfunction

	// Reset values: 18-base windows, no prefix, open bounds.
	task automatic test_reset_defaults();
		for (int i = 0; i < 19; i++)
			send_base(3'($urandom_range(0, 3)), i == 18);
		settle();
	endtask

	// A window length of 0 acts as one base, and a prefix longer than the window is
	// cut to it. Every symbol code is sent once, invalid ones included.
	task automatic test_length_limits();
		program_filter(0, 0, 32, 0, 128, 15, 16'h0002);
		for (int c = 0; c < 8; c++)
			send_base(3'(c), c == 7);
		settle();
	endtask

	// A length above the maximum acts as 32; then the length shrinks in the middle
	// of a sequence and applies at once to the bases already held.
	task automatic test_midstream_length_change();
		program_filter(63, 0, 32, 0, 128, 0, 16'h0000);
		send_base(3'd0, 1'b0);
		send_base(3'd1, 1'b0);
		send_base(3'd2, 1'b0);
		send_base(3'd3, 1'b0);
		settle();
		program_filter(2, 0, 32, 0, 128, 0, 16'h0000);
		send_base(3'd2, 1'b0);
		send_base(3'd1, 1'b1);
		settle();
	endtask

	// Tight bounds: exactly two G or C and temperature 12 in a 4-base window that must
	// open with G then C.
	task automatic test_prefix_and_bounds();
		program_filter(4, 2, 2, 12, 12, 2, 16'h0006);
		send_base(3'd2, 1'b0);
		send_base(3'd1, 1'b0);
		send_base(3'd0, 1'b0);
		send_base(3'd3, 1'b0);
		send_base(3'd2, 1'b1);
		settle();
	endtask

	// Random phases, each with its own register setting. Sequences often open with
	// the configured prefix so the prefix check passes now and then. A phase may end
	// in the middle of a sequence, which the next setting then continues.
	task automatic test_random_streams(input int phases, input int items_per_phase);
		int               n;
		int               plen;
		int               seq_left;
		int               idx;
		int               pre;
		int               min_gc;
		int               max_gc;
		int               min_t;
		int               max_t;
		int               len_v;
		int               r;
		logic [15:0]      pcode;
		logic [2:0]       code;
		for (int p = 0; p < phases; p++) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				len_v = 0;
			else if (r == 1)
				len_v = $urandom_range(33, 63);
			else if (r < 4)
				len_v = 32;
			else if (r < 10)
				len_v = $urandom_range(9, 31);
			else
				len_v = $urandom_range(1, 8);
			n = (len_v < 1) ? 1 : ((len_v > 32) ? 32 : len_v);
			r = $urandom_range(0, 9);
			if (r < 6) begin
				min_gc = $urandom_range(0, n / 3);
				max_gc = n - $urandom_range(0, n / 3);
			end else if (r < 8) begin
				min_gc = 0;
				max_gc = 32;
			end else begin
				min_gc = $urandom_range(0, 63);
				max_gc = $urandom_range(0, 63);
			end
			r = $urandom_range(0, 9);
			if (r < 6) begin
				min_t = 2 * n + $urandom_range(0, n / 2);
				max_t = min_t + $urandom_range(n / 2, 2 * n);
			end else if (r < 8) begin
				min_t = 0;
				max_t = 255;
			end else begin
				min_t = $urandom_range(0, 255);
				max_t = $urandom_range(0, 255);
			end
			r = $urandom_range(0, 19);
			plen = (r < 10) ? 0 : ((r < 17) ? $urandom_range(1, 3) : $urandom_range(4, 15));
			pcode = 16'($urandom);
			// The first two phases pin the extremes: the longest window with the
			// documented bound limits, and the shortest window with no G or C allowed.
			if (p == 0) begin
				len_v = 32; n = 32; min_gc = 0; max_gc = 32; min_t = 0; max_t = 128; plen = 0;
			end else if (p == 1) begin
				len_v = 1; n = 1; min_gc = 0; max_gc = 0; min_t = 0; max_t = 255; plen = 1;
			end
			program_filter(len_v, min_gc, max_gc, min_t, max_t, plen, pcode);
			if (plen > pwcf_pkg::MAX_PREFIX_LEN)
				plen = pwcf_pkg::MAX_PREFIX_LEN;
			if (plen > n)
				plen = n;
			// Every third phase runs the input flat out, every fourth the output.
			tx_idle_on = (p % 3) != 2;
			rx_idle_on = (p % 4) != 3;
			seq_left = 0;
			idx = 0;
			pre = 0;
			for (int k = 0; k < items_per_phase; k++) begin
				if (seq_left == 0) begin
					seq_left = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 2 * n + 6)
						: $urandom_range(n, 200);
					pre = (plen > 0 && $urandom_range(0, 1) == 1) ? plen : 0;
					idx = 0;
				end
				code = (idx < pre) ? {1'b0, pcode[2*idx +: 2]} : rand_base();
				seq_left--;
				idx++;
				send_base(code, seq_left == 0);
			end
			settle();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_length_limits();
		test_midstream_length_change();
		test_prefix_and_bounds();
		test_random_streams(12, 118);

		settle();
		if (mismatch_count == 0 && pending_windows.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
